### hdl/sasc_pkg.sv
// Shared constants, command/status types and address helper for the
// suffix automaton substring checker. No dependencies.
package sasc_pkg;

  localparam int MAX_TEXT   = 4096;
  localparam int ALPHABET   = 26;
  localparam int MAX_STATES = 2 * MAX_TEXT;
  localparam int SW         = $clog2(MAX_STATES);      // state index width
  localparam int CW         = SW + 1;                  // state count width
  localparam int SYW        = 5;                       // symbol port width
  localparam int IW         = $clog2(ALPHABET);        // row sweep index width
  localparam int TDEPTH     = MAX_STATES * ALPHABET;
  localparam int TAW        = $clog2(TDEPTH);

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_INIT   = 4'd1;
  localparam logic [3:0] OP_ACCEPT = 4'd2;
  localparam logic [3:0] OP_QRES   = 4'd3;
  localparam logic [3:0] OP_NEWLEN = 4'd4;
  localparam logic [3:0] OP_CLR    = 4'd5;
  localparam logic [3:0] OP_RDP    = 4'd6;
  localparam logic [3:0] OP_CHK    = 4'd7;
  localparam logic [3:0] OP_LENQ   = 4'd8;
  localparam logic [3:0] OP_COPY   = 4'd9;
  localparam logic [3:0] OP_RED1   = 4'd10;
  localparam logic [3:0] OP_RED2   = 4'd11;
  localparam logic [3:0] OP_RED3   = 4'd12;
  localparam logic [3:0] OP_FIN1   = 4'd13;
  localparam logic [3:0] OP_FIN2   = 4'd14;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic app_ok;     // append beat that extends the automaton
    logic is_query;
    logic edge_zero;  // edge(p,c) missing
    logic p_root;
    logic len_match;  // len[p]+1 == len[q]
    logic idx_last;   // row sweep at last symbol
    logic red_stop;   // edge(p,c) != q
    logic out_busy;
  } sts_t;

  function automatic logic [TAW-1:0] tr_addr(input logic [SW-1:0] st,
                                             input logic [SYW-1:0] sym);
    tr_addr = TAW'(st) * TAW'(ALPHABET) + TAW'(sym);
  endfunction

endpackage

### hdl/sasc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sasc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sasc_ctrl.sv
// Sequencer for the suffix automaton checker: input handshake and step order.
// Depends on sasc_pkg.
module sasc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          kind_i,
  input  logic          last_symbol_i,
  output logic          in_stall_o,
  input  sasc_pkg::sts_t sts_i,
  output sasc_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_QWAIT  = 4'd2;
  localparam logic [3:0] S_NEWLEN = 4'd3;
  localparam logic [3:0] S_CLR    = 4'd4;
  localparam logic [3:0] S_RDP    = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_LENQ   = 4'd7;
  localparam logic [3:0] S_COPY   = 4'd8;
  localparam logic [3:0] S_RED1   = 4'd9;
  localparam logic [3:0] S_RED2   = 4'd10;
  localparam logic [3:0] S_RED3   = 4'd11;
  localparam logic [3:0] S_FIN1   = 4'd12;
  localparam logic [3:0] S_FIN2   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       accept;

  // in idle, only a closing query beat waits, and only for the result slot
  assign in_stall_o = (state_q != S_IDLE) || (sts_i.out_busy && kind_i && last_symbol_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o.op = sasc_pkg::OP_NONE;
    case (state_q)
      S_INIT: begin
        cmd_o.op = sasc_pkg::OP_INIT;
        if (sts_i.idx_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = sasc_pkg::OP_ACCEPT;
          if (sts_i.is_query)    state_d = S_QWAIT;
          else if (sts_i.app_ok) state_d = S_NEWLEN;
        end
      end
      S_QWAIT: begin
        cmd_o.op = sasc_pkg::OP_QRES;
        state_d  = S_IDLE;
      end
      S_NEWLEN: begin
        cmd_o.op = sasc_pkg::OP_NEWLEN;
        state_d  = S_CLR;
      end
      S_CLR: begin
        cmd_o.op = sasc_pkg::OP_CLR;
        if (sts_i.idx_last) state_d = S_RDP;
      end
      S_RDP: begin
        cmd_o.op = sasc_pkg::OP_RDP;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.op = sasc_pkg::OP_CHK;
        if (!sts_i.edge_zero)  state_d = S_LENQ;
        else if (sts_i.p_root) state_d = S_IDLE;
        else                   state_d = S_RDP;
      end
      S_LENQ: begin
        cmd_o.op = sasc_pkg::OP_LENQ;
        state_d  = sts_i.len_match ? S_IDLE : S_COPY;
      end
      S_COPY: begin
        cmd_o.op = sasc_pkg::OP_COPY;
        if (sts_i.idx_last) state_d = S_RED1;
      end
      S_RED1: begin
        cmd_o.op = sasc_pkg::OP_RED1;
        state_d  = sts_i.p_root ? S_FIN1 : S_RED2;
      end
      S_RED2: begin
        cmd_o.op = sasc_pkg::OP_RED2;
        state_d  = S_RED3;
      end
      S_RED3: begin
        cmd_o.op = sasc_pkg::OP_RED3;
        state_d  = sts_i.red_stop ? S_FIN1 : S_RED1;
      end
      S_FIN1: begin
        cmd_o.op = sasc_pkg::OP_FIN1;
        state_d  = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.op = sasc_pkg::OP_FIN2;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("beat accepted while busy");
  a_init_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT && !sts_i.idx_last) |=> (state_q == S_INIT))
    else $error("root clear left early");
  a_query_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.is_query) |=> (state_q == S_QWAIT))
    else $error("query beat lost");

endmodule

### hdl/sasc_dp.sv
// Datapath: automaton memories, construction registers, query cursor, result.
// Depends on sasc_pkg and sasc_ram.
module sasc_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    kind_i,
  input  logic [sasc_pkg::SYW-1:0] symbol_i,
  input  logic                    last_symbol_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic                    found_o,
  output logic                    overflow_o,
  input  sasc_pkg::cmd_t          cmd_i,
  output sasc_pkg::sts_t          sts_o
);

  localparam int SW  = sasc_pkg::SW;
  localparam int CW  = sasc_pkg::CW;
  localparam int IW  = sasc_pkg::IW;
  localparam int SYW = sasc_pkg::SYW;
  localparam int TAW = sasc_pkg::TAW;

  logic [CW-1:0]  cnt_q;
  logic [SW-1:0]  last_q, cur_q, p_q, q_q, cl_q, lenp_q, cursor_q;
  logic           failed_q, ovf_q, fin_q, out_valid_q, found_q, ovo_q;
  logic [SYW-1:0] sym_q;
  logic [IW-1:0]  idx_q;

  logic           tr_we, ln_we, lk_we;
  logic [TAW-1:0] tr_wa, tr_ra;
  logic [SW-1:0]  tr_wd, tr_rd, ln_wa, ln_ra, ln_wd, ln_rd, lk_wa, lk_ra, lk_wd, lk_rd;

  logic           sym_ok, qmiss, idx_last;
  logic [SYW-1:0] symc;

  assign sym_ok   = symbol_i < SYW'(sasc_pkg::ALPHABET);
  assign symc     = sym_ok ? symbol_i : '0;
  assign idx_last = idx_q == IW'(sasc_pkg::ALPHABET - 1);
  assign qmiss    = failed_q || (sym_q >= SYW'(sasc_pkg::ALPHABET)) || (tr_rd == '0) ||
                    ({1'b0, tr_rd} >= cnt_q);

  always_comb begin
    sts_o.app_ok    = !kind_i && sym_ok &&
                      ((CW+1)'(cnt_q) + (CW+1)'(2) <= (CW+1)'(sasc_pkg::MAX_STATES));
    sts_o.is_query  = kind_i;
    sts_o.edge_zero = tr_rd == '0;
    sts_o.p_root    = p_q == '0;
    sts_o.len_match = (lenp_q + SW'(1)) == ln_rd;
    sts_o.idx_last  = idx_last;
    sts_o.red_stop  = tr_rd != q_q;
    sts_o.out_busy  = out_valid_q;
  end

  // memory port steering
  always_comb begin
    tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = '0;
    ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = '0;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = '0;
    case (cmd_i.op)
      sasc_pkg::OP_INIT: begin
        tr_we = 1'b1;
        tr_wa = sasc_pkg::tr_addr('0, SYW'(idx_q));
        ln_we = idx_q == '0;
        lk_we = idx_q == '0;
      end
      sasc_pkg::OP_ACCEPT: begin
        ln_ra = last_q;
        tr_ra = sasc_pkg::tr_addr(cursor_q, symc);
      end
      sasc_pkg::OP_NEWLEN: begin
        ln_we = 1'b1; ln_wa = cur_q; ln_wd = ln_rd + SW'(1);
        lk_we = 1'b1; lk_wa = cur_q;
      end
      sasc_pkg::OP_CLR: begin
        tr_we = 1'b1;
        tr_wa = sasc_pkg::tr_addr(cur_q, SYW'(idx_q));
      end
      sasc_pkg::OP_RDP: begin
        tr_ra = sasc_pkg::tr_addr(p_q, sym_q);
        ln_ra = p_q;
        lk_ra = p_q;
      end
      sasc_pkg::OP_CHK: begin
        if (tr_rd == '0) begin
          tr_we = 1'b1; tr_wa = sasc_pkg::tr_addr(p_q, sym_q); tr_wd = cur_q;
        end
        ln_ra = tr_rd;
      end
      sasc_pkg::OP_LENQ: begin
        if ((lenp_q + SW'(1)) == ln_rd) begin
          lk_we = 1'b1; lk_wa = cur_q; lk_wd = q_q;
        end else begin
          ln_we = 1'b1; ln_wa = cnt_q[SW-1:0]; ln_wd = lenp_q + SW'(1);
        end
        tr_ra = sasc_pkg::tr_addr(q_q, '0);
        lk_ra = q_q;
      end
      sasc_pkg::OP_COPY: begin
        tr_we = 1'b1; tr_wa = sasc_pkg::tr_addr(cl_q, SYW'(idx_q)); tr_wd = tr_rd;
        tr_ra = sasc_pkg::tr_addr(q_q, SYW'(idx_q) + SYW'(1));
        lk_ra = q_q;
        lk_we = idx_q == '0; lk_wa = cl_q; lk_wd = lk_rd;
      end
      sasc_pkg::OP_RED1: begin
        tr_we = 1'b1; tr_wa = sasc_pkg::tr_addr(p_q, sym_q); tr_wd = cl_q;
        lk_ra = p_q;
      end
      sasc_pkg::OP_RED2: begin
        tr_ra = sasc_pkg::tr_addr(lk_rd, sym_q);
      end
      sasc_pkg::OP_FIN1: begin
        lk_we = 1'b1; lk_wa = q_q; lk_wd = cl_q;
      end
      sasc_pkg::OP_FIN2: begin
        lk_we = 1'b1; lk_wa = cur_q; lk_wd = cl_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CW'(1);
      last_q      <= '0;
      cursor_q    <= '0;
      failed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        sasc_pkg::OP_INIT, sasc_pkg::OP_CLR, sasc_pkg::OP_COPY: begin
          idx_q <= idx_last ? '0 : idx_q + IW'(1);
        end
        sasc_pkg::OP_ACCEPT: begin
          if (sts_o.app_ok) begin
            cnt_q  <= cnt_q + CW'(1);
            last_q <= cnt_q[SW-1:0];
          end else if (!kind_i && sym_ok) begin
            ovf_q <= 1'b1;
          end
        end
        sasc_pkg::OP_QRES: begin
          if (fin_q) begin
            cursor_q    <= '0;
            failed_q    <= 1'b0;
            out_valid_q <= 1'b1;
          end else begin
            failed_q <= qmiss;
            if (!qmiss) cursor_q <= tr_rd;
          end
        end
        sasc_pkg::OP_NEWLEN: idx_q <= '0;
        sasc_pkg::OP_LENQ: begin
          idx_q <= '0;
          if ((lenp_q + SW'(1)) != ln_rd) cnt_q <= cnt_q + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sasc_pkg::OP_ACCEPT: begin
        sym_q <= symbol_i;
        fin_q <= last_symbol_i;
        cur_q <= cnt_q[SW-1:0];
        p_q   <= last_q;
      end
      sasc_pkg::OP_QRES: begin
        if (fin_q) begin
          found_q <= !qmiss;
          ovo_q   <= ovf_q;
        end
      end
      sasc_pkg::OP_CHK: begin
        lenp_q <= ln_rd;
        if (tr_rd == '0) p_q <= lk_rd;
        else             q_q <= tr_rd;
      end
      sasc_pkg::OP_LENQ: cl_q <= cnt_q[SW-1:0];
      sasc_pkg::OP_RED2: p_q  <= lk_rd;
      default: ;
    endcase
  end

  sasc_ram #(.W(SW), .D(sasc_pkg::TDEPTH)) u_trans (
    .clk_i, .we_i(tr_we), .waddr_i(tr_wa), .wdata_i(tr_wd), .raddr_i(tr_ra), .rdata_o(tr_rd)
  );
  sasc_ram #(.W(SW), .D(sasc_pkg::MAX_STATES)) u_len (
    .clk_i, .we_i(ln_we), .waddr_i(ln_wa), .wdata_i(ln_wd), .raddr_i(ln_ra), .rdata_o(ln_rd)
  );
  sasc_ram #(.W(SW), .D(sasc_pkg::MAX_STATES)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd), .raddr_i(lk_ra), .rdata_o(lk_rd)
  );

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign overflow_o  = ovo_q;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(sasc_pkg::MAX_STATES)) else $error("state count past table");
  a_last_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, last_q} < cnt_q) else $error("last state not allocated");
  a_cursor_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cursor_q} < cnt_q) else $error("cursor on unallocated state");
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q) else $error("overflow flag cleared");

endmodule

### hdl/suffix_automaton_substring_check.sv
// Suffix automaton substring checker: online construction plus query walk.
// Query beat: after acceptance a QWAIT step moves the cursor or, for a closing
// beat, registers the result; the next beat is taken back in idle. Append:
// clear the new row, walk suffix links until an edge exists; a clone redirects edges.
// After reset: a pass clearing the root row, no beats accepted meanwhile.
// Depends on sasc_pkg, sasc_ctrl, sasc_dp (which uses sasc_ram).
module suffix_automaton_substring_check (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [sasc_pkg::SYW-1:0] symbol_i,
  input  logic                     last_symbol_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic                     overflow_o
);

  // controller <-> datapath: command down, status up
  sasc_pkg::cmd_t cmd;
  sasc_pkg::sts_t sts;

  // step sequencer; holds the input stall while a beat is in work
  sasc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .kind_i, .last_symbol_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  // memories, construction state, query cursor and the result register
  sasc_dp u_dp (
    .clk_i, .rst_ni, .kind_i, .symbol_i, .last_symbol_i, .out_stall_i,
    .out_valid_o, .found_o, .overflow_o, .cmd_i(cmd), .sts_o(sts)
  );

endmodule
